/* design/rprt_pkg.sv */
package rprt_pkg;

  typedef enum logic [1:0] {
    OP_REMEMBER = 2'd0,
    OP_ACK      = 2'd1,
    OP_TICK     = 2'd2,
    OP_DATA     = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_RESEND = 2'd0,
    KIND_ACK    = 2'd1,
    KIND_FULL   = 2'd2,
    KIND_RSVD   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] seq_id;
    logic [7:0]  packet_handle;
    logic        reliable;
    logic        already_sent;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] out_seq_id;
    logic [7:0]  out_handle;
    logic        last;
  } out_item_t;

endpackage

/* design/rprt_cell.sv */
// One slot of the queue. Entries stay packed toward cell 0 in age order.
// Each walk step rotates the occupied part of the row by one: cell 0 hands
// to the tail cell (last occupied), every other cell takes from its upper
// neighbor. The neighbor selection lives in the top level.
module rprt_cell #(
  parameter int unsigned TimerBits = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 shift_i,
  input  logic                 load_i,
  input  logic                 clear_i,
  input  logic                 restamp_i,
  input  logic [TimerBits-1:0] now_i,
  input  logic                 nb_valid_i,
  input  logic [15:0]          nb_seq_i,
  input  logic [7:0]           nb_handle_i,
  input  logic [TimerBits-1:0] nb_time_i,
  input  logic [15:0]          ld_seq_i,
  input  logic [7:0]           ld_handle_i,
  output logic                 valid_o,
  output logic [15:0]          seq_o,
  output logic [7:0]           handle_o,
  output logic [TimerBits-1:0] time_o
);
  logic                 valid_q;
  logic [15:0]          seq_q;
  logic [7:0]           handle_q;
  logic [TimerBits-1:0] time_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (shift_i) begin
      valid_q <= nb_valid_i & ~clear_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      seq_q    <= ld_seq_i;
      handle_q <= ld_handle_i;
      time_q   <= now_i;
    end else if (shift_i) begin
      seq_q    <= nb_seq_i;
      handle_q <= nb_handle_i;
      time_q   <= restamp_i ? now_i : nb_time_i;
    end
  end

  assign valid_o  = valid_q;
  assign seq_o    = seq_q;
  assign handle_o = handle_q;
  assign time_o   = time_q;
endmodule

/* design/reliable_packet_retransmit_table_top.sv */
// Channel | dir | handshake          | payload
// in      | in  | in_valid/in_stall  | rprt_pkg::in_item_t
// out     | out | out_valid/out_stall| rprt_pkg::out_item_t
// cfg     | in  | cfg_valid/cfg_ready| resend_interval (16b)
// Remember and data go from accept straight to the emit state. Ack and tick walk
// the stored entries, one per cycle unless a held output beat stalls a tick walk.
// Reset clears the row's valid bits, count, timer; interval goes to 100.
// A held output beat holds the emit cycle and stalls a tick walk at a due entry
// once one is pending; in_stall is high from accept until the emit cycle is done.
module reliable_packet_retransmit_table_top #(
  parameter int unsigned Depth     = 16,
  parameter int unsigned TimerBits = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid,
  output logic                in_stall,
  input  rprt_pkg::in_item_t  in_data_i,
  output logic                out_valid,
  input  logic                out_stall,
  output rprt_pkg::out_item_t out_data_o,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [15:0]         cfg_data_i
);
  import rprt_pkg::*;

  localparam int unsigned CntW = $clog2(Depth + 1);

  state_e state_q, state_d;
  in_item_t item_q;
  logic [15:0] interval_q;
  logic [TimerBits-1:0] now_q;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] rem_q; // walk steps left
  logic found_q;
  logic out_valid_q;
  out_item_t out_q;
  logic pend_q; // a resend beat held in hold_q, not yet emitted or known to be last
  out_item_t pend_d_item;

  logic [Depth-1:0] c_valid;
  logic [15:0] c_seq [Depth];
  logic [7:0] c_handle [Depth];
  logic [TimerBits-1:0] c_time [Depth];

  logic shift, load, clear_h, restamp_h, due_h, out_free, accept;
  logic [TimerBits-1:0] age_h;

  assign out_free = ~out_valid_q | ~out_stall;
  assign in_stall = (state_q != ST_IDLE);
  assign accept   = in_valid & ~in_stall;
  assign cfg_ready = (state_q == ST_IDLE);

  // head cell (0) is inspected each walk step
  assign age_h = now_q - c_time[0];
  assign due_h = c_valid[0] & (age_h > {{(TimerBits-16){1'b0}}, interval_q});
  // a due head during tick needs one output beat slot if a resend is pending
  assign shift = (state_q == ST_WALK) && (rem_q != '0) &&
                 !(item_q.operation == OP_TICK && due_h && pend_q && !out_free);
  assign clear_h = (item_q.operation == OP_ACK) && !found_q && c_valid[0] &&
                   (c_seq[0] == item_q.seq_id);
  assign restamp_h = (item_q.operation == OP_TICK) && due_h;
  assign load = (state_q == ST_EMIT) && out_free && (item_q.operation == OP_REMEMBER) &&
                item_q.reliable && !item_q.already_sent && (count_q != CntW'(Depth));

  // The tail cell (count - 1) takes the head; a cleared head is dropped
  // there, so the row shrinks by one and stays packed. Walking the count at
  // accept brings every remaining entry back to its rank.
  for (genvar g = 0; g < Depth; g++) begin : g_row
    logic                 wrap;
    logic                 nb_valid;
    logic [15:0]          nb_seq;
    logic [7:0]           nb_handle;
    logic [TimerBits-1:0] nb_time;

    assign wrap = (count_q == CntW'(g + 1));

    if (g == Depth - 1) begin : g_end
      assign nb_valid  = wrap & c_valid[0];
      assign nb_seq    = c_seq[0];
      assign nb_handle = c_handle[0];
      assign nb_time   = c_time[0];
    end else begin : g_mid
      assign nb_valid  = wrap ? c_valid[0]  : c_valid[g + 1];
      assign nb_seq    = wrap ? c_seq[0]    : c_seq[g + 1];
      assign nb_handle = wrap ? c_handle[0] : c_handle[g + 1];
      assign nb_time   = wrap ? c_time[0]   : c_time[g + 1];
    end

    rprt_cell #(.TimerBits(TimerBits)) u_cell (
      .clk_i, .rst_ni,
      .shift_i    (shift),
      .load_i     (load && (count_q == CntW'(g))),
      .clear_i    (wrap & clear_h),
      .restamp_i  (wrap & restamp_h),
      .now_i      (now_q),
      .nb_valid_i (nb_valid),
      .nb_seq_i   (nb_seq),
      .nb_handle_i(nb_handle),
      .nb_time_i  (nb_time),
      .ld_seq_i   (item_q.seq_id),
      .ld_handle_i(item_q.packet_handle),
      .valid_o    (c_valid[g]),
      .seq_o      (c_seq[g]),
      .handle_o   (c_handle[g]),
      .time_o     (c_time[g])
    );
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept) state_d = (in_data_i.operation == OP_ACK ||
                                      in_data_i.operation == OP_TICK) ? ST_WALK : ST_EMIT;
      ST_WALK: if (rem_q == '0 || (shift && rem_q == CntW'(1))) state_d = ST_EMIT;
      ST_EMIT: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (load) count_d = count_q + 1'b1;
    else if (shift && clear_h) count_d = count_q - 1'b1;
  end

  always_comb begin
    pend_d_item.kind       = KIND_RESEND;
    pend_d_item.out_seq_id = c_seq[0];
    pend_d_item.out_handle = c_handle[0];
    pend_d_item.last       = 1'b0;
  end

  out_item_t hold_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      interval_q  <= 16'd100;
      now_q       <= '0;
      count_q     <= '0;
      rem_q       <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (cfg_valid && cfg_ready) interval_q <= cfg_data_i;
      if (accept) begin
        rem_q   <= count_q;
        found_q <= 1'b0;
        pend_q  <= 1'b0;
        if (in_data_i.operation == OP_TICK) now_q <= now_q + 1'b1;
      end
      if (shift) begin
        rem_q <= rem_q - 1'b1;
        if (clear_h) found_q <= 1'b1;
        if (restamp_h) pend_q <= 1'b1;
      end
      if (state_q == ST_EMIT && out_free) begin
        unique case (op_e'(item_q.operation))
          OP_REMEMBER: out_valid_q <= item_q.reliable && !item_q.already_sent &&
                                      (count_q == CntW'(Depth));
          OP_DATA:     out_valid_q <= (item_q.seq_id != 16'd0);
          OP_TICK:     out_valid_q <= pend_q;
          default:     out_valid_q <= 1'b0;
        endcase
        pend_q <= 1'b0;
      end else if (shift && restamp_h && pend_q) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) item_q <= in_data_i;
    if (shift && restamp_h) begin
      hold_q <= pend_d_item;
      if (pend_q) out_q <= hold_q;
    end
    if (state_q == ST_EMIT && out_free) begin
      unique case (op_e'(item_q.operation))
        OP_REMEMBER: out_q <= '{KIND_FULL, item_q.seq_id, item_q.packet_handle, 1'b1};
        OP_DATA:     out_q <= '{KIND_ACK, item_q.seq_id, 8'd0, 1'b1};
        OP_TICK:     out_q <= '{hold_q.kind, hold_q.out_seq_id, hold_q.out_handle, 1'b1};
        default:     out_q <= out_q;
      endcase
    end
  end

  assign out_valid  = out_valid_q;
  assign out_data_o = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth)) else $error("count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_stall |=> out_valid && $stable(out_data_o))
    else $error("held beat changed");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> in_stall) else $error("accept during walk");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(found_q) |-> $past(item_q.operation) == OP_ACK)
    else $error("clear outside ack");
endmodule
